// File: design/cdq_pkg.sv
// Package for the circular deque: word type, request and status codes,
// and the command group broadcast to the storage cells. No dependencies.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_REAR  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_REAR   = 3'd3,
      FUNC_PEEK_FRONT = 3'd4,
      FUNC_PEEK_REAR  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // Command shared by every cell in the row.
   typedef struct packed {
      logic shift_right;  // push at the front: every entry moves one cell back
      logic shift_left;   // pop at the front: every entry moves one cell forward
      logic fill_rear;    // push at the rear: the first free cell takes the word
      logic drop_rear;    // pop at the rear: the last held cell lets go
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: design/cdq_ifs.sv
// Handshake channels of the circular deque: request and response.
// Depends on cdq_pkg for the word type.
`default_nettype none

interface cdq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   cdq_pkg::word_type  push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   logic               valid;
   logic               ready;
   cdq_pkg::word_type  read_value;
   logic [1:0]         status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink   (input valid, input read_value, input status, output ready);
endinterface

`default_nettype wire

// File: design/cdq_cell.sv
// One storage cell of the deque row: holds a word and a valid bit and trades
// its word with its neighbors on a shift. Depends on cdq_pkg.
`default_nettype none

module cdq_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  cdq_pkg::cell_cmd_type cmd,
   input  cdq_pkg::word_type     push_value,
   input  cdq_pkg::word_type     left_data,
   input  wire                   left_valid,
   input  cdq_pkg::word_type     right_data,
   input  wire                   right_valid,
   output cdq_pkg::word_type     data_out,
   output logic                  valid_out,
   output cdq_pkg::word_type     rear_data
);
   import cdq_pkg::*;

   word_type data_ff;
   word_type data_in;
   logic     valid_ff;
   logic     valid_in;
   logic     is_rear;

   // The held entries always fill the row from cell zero, so the rear entry
   // is the one held cell whose right neighbor is free.
   assign is_rear = valid_ff && !right_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (cmd.shift_right) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (cmd.shift_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (cmd.fill_rear && !valid_ff && left_valid) begin
         data_in  = push_value;
         valid_in = 1'b1;
      end else if (cmd.drop_rear && is_rear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign rear_data = is_rear ? data_ff : '0;

endmodule

`default_nettype wire

// File: design/circular_deque.sv
// Top level of the circular deque: decodes requests, drives the cell row
// and registers the response. Depends on cdq_pkg, cdq_ifs and cdq_cell.
//
// The deque holds up to DEPTH words in a row of cells with the front entry
// always in the first cell; a push or pop at the front shifts the whole row
// by one, a push or pop at the rear touches only the cell at the boundary of
// the held entries. Every request gives exactly one response, registered in
// the cycle after the transaction is accepted, and a new request is taken
// every cycle as long as the response side keeps up; the response register
// is the only thing that can hold the request side back. Pushes to a full
// deque report overflow and change nothing, pops and peeks on an empty
// deque report underflow, and unused request codes return zero with an ok
// status. There is no setup after reset.
`default_nettype none

module circular_deque (
   input wire           clock,
   input wire           reset,
   cdq_req_if.sink      req_ch,
   cdq_rsp_if.source    rsp_ch
);
   import cdq_pkg::*;

   logic         accept;
   logic         full;
   logic         empty;
   cell_cmd_type cmd;
   logic [DEPTH-1:0] cell_valid;
   word_type     cell_data [DEPTH];
   word_type     cell_rear [DEPTH];
   word_type     rear_value;
   word_type     read_value_in;
   status_type   status_in;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   word_type     rsp_read_value_ff;
   status_type   rsp_status_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign empty        = !cell_valid[0];
   assign full         = cell_valid[DEPTH-1];

   always_comb begin
      rear_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_value = rear_value | cell_rear[i];
      end
   end

   always_comb begin
      cmd           = '0;
      read_value_in = '0;
      status_in     = STATUS_OK;
      case (req_ch.func)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (full) begin
               status_in = STATUS_OVERFLOW;
            end else if (req_ch.func == FUNC_PUSH_FRONT) begin
               cmd.shift_right = accept;
            end else begin
               cmd.fill_rear = accept;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_REAR, FUNC_PEEK_FRONT, FUNC_PEEK_REAR: begin
            if (empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               if (req_ch.func inside {FUNC_POP_FRONT, FUNC_PEEK_FRONT}) begin
                  read_value_in = cell_data[0];
               end else begin
                  read_value_in = rear_value;
               end
               cmd.shift_left = accept && (req_ch.func == FUNC_POP_FRONT);
               cmd.drop_rear  = accept && (req_ch.func == FUNC_POP_REAR);
            end
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_data;
      logic     left_valid;
      word_type right_data;
      logic     right_valid;

      if (i == 0) begin : g_first
         // The first cell takes the pushed word on a front shift.
         assign left_data  = req_ch.push_value;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .push_value  (req_ch.push_value),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data_out    (cell_data[i]),
         .valid_out   (cell_valid[i]),
         .rear_data   (cell_rear[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= read_value_in;
         rsp_status_ff     <= status_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_read_value_ff;
   assign rsp_ch.status     = rsp_status_ff;

`ifndef SYNTHESIS
   // Held entries form a single unbroken run of cells.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_valid & ~(cell_valid >> 1)))
      else $error("deque cells are not filled contiguously");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req_ch.func == FUNC_PUSH_FRONT || req_ch.func == FUNC_PUSH_REAR))
      |=> cell_valid[0])
      else $error("accepted push left the deque empty");

   a_overflow_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && full && (req_ch.func == FUNC_PUSH_FRONT || req_ch.func == FUNC_PUSH_REAR))
      |=> ($stable(cell_valid) && rsp_ch.status == STATUS_OVERFLOW))
      else $error("push to a full deque changed its contents");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (accept && empty && (req_ch.func == FUNC_POP_FRONT || req_ch.func == FUNC_POP_REAR ||
                           req_ch.func == FUNC_PEEK_FRONT || req_ch.func == FUNC_PEEK_REAR))
      |=> (rsp_ch.status == STATUS_UNDERFLOW && rsp_ch.read_value == '0))
      else $error("read of an empty deque did not report underflow");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted transaction gave no response");
`endif

endmodule

`default_nettype wire

// File: tb/cdq_response_checker.sv
// Response checker for the circular deque: watches both channels, predicts
// each response from its own deque model and compares. Depends on cdq_pkg.
`timescale 1ns / 100ps

module cdq_response_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  wire [2:0]          req_func,
   input  cdq_pkg::word_type  req_push_value,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  cdq_pkg::word_type  rsp_read_value,
   input  wire [1:0]          rsp_status,
   output int                 error_count,
   output int                 outstanding
);
   import cdq_pkg::*;

   typedef struct packed {
      word_type   read_value;
      status_type status;
   } rsp_item_type;

   rsp_item_type awaited_rsp_q[$];

   // Model state: circular store with front and rear entry indexes.
   word_type deque_mem [DEPTH];
   int       head_idx;
   int       tail_idx;
   bit       deque_empty;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic int wrap_up(input int i);
      return (i >= DEPTH - 1) ? 0 : i + 1;
   endfunction

   function automatic int wrap_down(input int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   // Applies one request to the model and returns the response it must give.
   function automatic rsp_item_type apply_request(input logic [2:0] f, input word_type w);
      rsp_item_type r;
      bit           full;
      r.read_value = '0;
      r.status     = STATUS_OK;
      full = !deque_empty && (wrap_up(tail_idx) == head_idx);
      case (f)
         FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
            if (full) begin
               r.status = STATUS_OVERFLOW;
            end else if (deque_empty) begin
               deque_empty  = 1'b0;
               head_idx     = 0;
               tail_idx     = 0;
               deque_mem[0] = w;
            end else if (f == FUNC_PUSH_FRONT) begin
               head_idx = wrap_down(head_idx);
               deque_mem[head_idx] = w;
            end else begin
               tail_idx = wrap_up(tail_idx);
               deque_mem[tail_idx] = w;
            end
         end
         FUNC_POP_FRONT, FUNC_POP_REAR: begin
            if (deque_empty) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.read_value = deque_mem[(f == FUNC_POP_FRONT) ? head_idx : tail_idx];
               // Taking the last entry returns both indexes to the start.
               if (head_idx == tail_idx) begin
                  deque_empty = 1'b1;
                  head_idx    = 0;
                  tail_idx    = 0;
               end else if (f == FUNC_POP_FRONT) begin
                  head_idx = wrap_up(head_idx);
               end else begin
                  tail_idx = wrap_down(tail_idx);
               end
            end
         end
         FUNC_PEEK_FRONT, FUNC_PEEK_REAR: begin
            if (deque_empty)
               r.status = STATUS_UNDERFLOW;
            else
               r.read_value = deque_mem[(f == FUNC_PEEK_FRONT) ? head_idx : tail_idx];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_item_type exp_item;
      if (reset) begin
         awaited_rsp_q.delete();
         head_idx    = 0;
         tail_idx    = 0;
         deque_empty = 1'b1;
      end else begin
         // The response of this edge belongs to an older request, so it is
         // retired before the request of this edge is predicted.
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp_q.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: response with none awaited: read_value %h status %0d",
                           $realtime, rsp_read_value, rsp_status);
               error_count++;
            end else begin
               exp_item = awaited_rsp_q.pop_front();
               if (rsp_read_value !== exp_item.read_value ||
                   rsp_status !== exp_item.status) begin
                  if (error_count < 10)
                     $display("%0t: mismatch: read_value %h status %0d, expected %h status %0d",
                              $realtime, rsp_read_value, rsp_status,
                              exp_item.read_value, exp_item.status);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_rsp_q.push_back(apply_request(req_func, req_push_value));
      end
      outstanding <= awaited_rsp_q.size();
   end

endmodule

// File: tb/tb_circular_deque.sv
// Top of the circular deque testbench: clock, reset, request and response
// traffic, and the verdict. Depends on cdq_pkg, cdq_ifs, the block and the checker.
`timescale 1ns / 100ps

module tb_circular_deque;
   import cdq_pkg::*;

   localparam int          RANDOM_ITEMS = 1830;
   localparam int          CYCLE_LIMIT  = 200_000;
   localparam int          HOLD_CYCLES  = 80;
   localparam logic [2:0]  FUNC_UNUSED_LO = 3'd6;
   localparam logic [2:0]  FUNC_UNUSED_HI = 3'd7;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;

   logic clock;
   logic reset;
   logic quiet_phase = 1'b0;
   logic start_hold  = 1'b0;
   int   error_count;
   int   outstanding;
   int   cycle_count = 0;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cdq_response_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_func       (req_ch.func),
      .req_push_value (req_ch.push_value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_read_value (rsp_ch.read_value),
      .rsp_status     (rsp_ch.status),
      .error_count    (error_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: random idling, none in the quiet window, and one long hold-off.
   initial begin : receiver
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (start_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= 22);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic word_type random_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh0000_0000;
         1:       return -32'sd1;
         2:       return 32'sh7FFF_FFFF;
         3:       return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_func(input traffic_mix_type mix);
      int roll;
      int push_share;
      int pop_share;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin push_share = 70; pop_share = 15; end
         MIX_DRAIN: begin push_share = 15; pop_share = 65; end
         default:   begin push_share = 40; pop_share = 35; end
      endcase
      if (roll < 4)
         return $urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
      else if (roll < 4 + push_share)
         return $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
      else if (roll < 4 + push_share + pop_share)
         return $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_REAR;
      else
         return $urandom_range(0, 1) ? FUNC_PEEK_FRONT : FUNC_PEEK_REAR;
   endfunction

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_request(input logic [2:0] f, input word_type v);
      int gap;
      gap = 0;
      // Each idle cycle is drawn on its own, so about a fifth of cycles idle.
      while (!quiet_phase && $urandom_range(0, 99) < 22)
         gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.push_value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      int              sent;
      int              phase_len;
      bit              paused_once;
      traffic_mix_type mix;
      sent        = 0;
      paused_once = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_PEEK_FRONT;
      req_ch.push_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Underflow on every read of the empty deque.
      send_request(FUNC_PEEK_FRONT, -32'sd1);
      send_request(FUNC_PEEK_REAR, 32'sh7FFF_FFFF);
      send_request(FUNC_POP_FRONT, 32'sh8000_0000);
      send_request(FUNC_POP_REAR, 32'sh0);
      // Push into the empty deque from either end, and pop of the last entry.
      send_request(FUNC_PUSH_REAR, 32'sh8000_0000);
      send_request(FUNC_POP_FRONT, 32'sh0);
      send_request(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(FUNC_PUSH_REAR, 32'sh0);
      send_request(FUNC_PUSH_FRONT, -32'sd1);
      send_request(FUNC_PEEK_FRONT, 32'sh0);
      send_request(FUNC_PEEK_REAR, -32'sd1);
      // Unused codes leave the deque alone.
      send_request(FUNC_UNUSED_LO, -32'sd1);
      send_request(FUNC_UNUSED_HI, 32'sh5A5A_A5A5);
      send_request(FUNC_POP_REAR, 32'sh0);
      send_request(FUNC_POP_FRONT, 32'sh0);
      send_request(FUNC_POP_REAR, 32'sh0);
      send_request(FUNC_POP_FRONT, 32'sh0);

      // Random phases biased toward filling or draining, so that the deque
      // runs full, wraps around and empties again many times.
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0 || (!paused_once && sent >= 1400)) begin
            paused_once = 1'b1;
            wait_until_drained();
         end
         case ($urandom_range(0, 2))
            0:       mix = MIX_FILL;
            1:       mix = MIX_DRAIN;
            default: mix = MIX_BALANCED;
         endcase
         phase_len = $urandom_range(20, 70);
         repeat (phase_len) begin
            if (sent < RANDOM_ITEMS) begin
               quiet_phase <= (sent >= 600 && sent < 850);
               if (sent == 1000)
                  start_hold <= 1'b1;
               send_request(pick_func(mix), random_word());
               sent++;
            end
         end
      end
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: circular_deque.f
design/cdq_pkg.sv
design/cdq_ifs.sv
design/cdq_cell.sv
design/circular_deque.sv
tb/cdq_response_checker.sv
tb/tb_circular_deque.sv
